FILE: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_DIS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_NODIS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: design/pim_pkg.sv
// shared types and constants of the point in mesh test
package pim_pkg;

  localparam int OP_W      = 2;
  localparam int SLOT_W    = 10;
  localparam int CORNER_W  = 10;
  localparam int CFG_W     = 11;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_FACES    = 1024;
  localparam int VIDX_W       = 10;
  localparam int FIDX_W       = 10;
  localparam int FCNT_W       = 11;
  localparam int FACE_W       = 3 * CORNER_W;
  localparam int PIPE_STAGES  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_VERTEX = 2'd0,
    OP_FACE   = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_vertex;
    logic wr_face;
    logic load_query;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic hit_seen;
    logic pipe_empty;
  } sts_t;

endpackage

FILE: design/pim_ctrl.sv
// controller: decodes incoming words and sequences the face walk
module pim_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pim_pkg::OP_W-1:0] op,
  input  pim_pkg::sts_t            sts,
  output pim_pkg::cmd_t            cmd,
  output logic                     busy,
  output logic                     done
);

  pim_pkg::state_t state;
  pim_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pim_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      pim_pkg::ST_IDLE: begin
        if (start) begin
          unique case (op)
            pim_pkg::OP_VERTEX: cmd.wr_vertex = 1'b1;
            pim_pkg::OP_FACE:   cmd.wr_face = 1'b1;
            pim_pkg::OP_QUERY: begin
              cmd.load_query = 1'b1;
              state_next     = pim_pkg::ST_WALK;
            end
            default: ;
          endcase
        end
      end
      pim_pkg::ST_WALK: begin
        if (sts.walk_done || sts.hit_seen) begin
          state_next = pim_pkg::ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      pim_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = pim_pkg::ST_DONE;
        end
      end
      pim_pkg::ST_DONE: state_next = pim_pkg::ST_IDLE;
      default: state_next = pim_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != pim_pkg::ST_IDLE);
  assign done = (state == pim_pkg::ST_DONE);

endmodule

FILE: design/pim_dpath.sv
// datapath: mesh tables, face walk counter and barycentric test pipeline
module pim_dpath #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pim_pkg::cmd_t                  cmd,
  input  logic [pim_pkg::SLOT_W-1:0]     slot,
  input  logic signed [COORD_BITS-1:0]   coord_x,
  input  logic signed [COORD_BITS-1:0]   coord_z,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_a,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_b,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_c,
  input  logic                           cfg_we,
  input  logic [pim_pkg::CFG_W-1:0]      cfg_data,
  output pim_pkg::sts_t                  sts,
  output logic                           inside_res
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int SW  = 2 * CW + 3;
  localparam int AW  = 2 * CW + 4;
  localparam int VW  = 2 * CW;
  localparam int NS  = pim_pkg::PIPE_STAGES;
  localparam int CRW = pim_pkg::CORNER_W;

  // tables, one vertex copy per corner so each is read once a cycle
  logic [pim_pkg::FACE_W-1:0] face_mem [pim_pkg::MAX_FACES];
  logic [VW-1:0]              vtx_mem_a [pim_pkg::MAX_VERTICES];
  logic [VW-1:0]              vtx_mem_b [pim_pkg::MAX_VERTICES];
  logic [VW-1:0]              vtx_mem_c [pim_pkg::MAX_VERTICES];

  // control state
  logic [pim_pkg::CFG_W-1:0]  faces_in_use;
  logic [pim_pkg::FCNT_W-1:0] face_idx;
  logic [pim_pkg::FCNT_W-1:0] face_limit;
  logic [NS-1:0]              vld;
  logic                       hit_any;

  // payload
  logic signed [CW-1:0]       px;
  logic signed [CW-1:0]       pz;
  logic [pim_pkg::FACE_W-1:0] face_q;
  logic [VW-1:0]              vq_a;
  logic [VW-1:0]              vq_b;
  logic [VW-1:0]              vq_c;
  logic signed [DW-1:0]       ex1, ez1, ex2, ez2, qx, qz;
  logic signed [PW-1:0]       pr_d1, pr_d2, pr_s1, pr_s2, pr_t1, pr_t2;
  logic signed [SW-1:0]       area, s_num, t_num;
  logic signed [SW-1:0]       area_n, s_n, t_n;

  logic signed [CW-1:0]       x0, z0, x1, z1, x2, z2;
  logic signed [AW-1:0]       st_sum;
  logic                       face_hit;
  logic [pim_pkg::FCNT_W-1:0] limit_next;

  always_comb begin
    if (faces_in_use > pim_pkg::FCNT_W'(pim_pkg::MAX_FACES)) begin
      limit_next = pim_pkg::FCNT_W'(pim_pkg::MAX_FACES);
    end else begin
      limit_next = faces_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      faces_in_use <= '0;
      face_idx     <= '0;
      face_limit   <= '0;
      vld          <= '0;
      hit_any      <= 1'b0;
    end else begin
      if (cfg_we) begin
        faces_in_use <= cfg_data;
      end
      if (cmd.load_query) begin
        face_idx   <= '0;
        face_limit <= limit_next;
      end else if (cmd.issue) begin
        face_idx <= face_idx + 1'b1;
      end
      vld <= {vld[NS-2:0], cmd.issue};
      if (cmd.load_query) begin
        hit_any <= 1'b0;
      end else if (vld[NS-1] && face_hit) begin
        hit_any <= 1'b1;
      end
    end
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_face) begin
      face_mem[slot[pim_pkg::FIDX_W-1:0]] <= {corner_a, corner_b, corner_c};
    end
    if (cmd.issue) begin
      face_q <= face_mem[face_idx[pim_pkg::FIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vertex) begin
      vtx_mem_a[slot[pim_pkg::VIDX_W-1:0]] <= {coord_x, coord_z};
      vtx_mem_b[slot[pim_pkg::VIDX_W-1:0]] <= {coord_x, coord_z};
      vtx_mem_c[slot[pim_pkg::VIDX_W-1:0]] <= {coord_x, coord_z};
    end
    if (vld[0]) begin
      vq_a <= vtx_mem_a[face_q[3*CRW-1 -: pim_pkg::VIDX_W]];
      vq_b <= vtx_mem_b[face_q[2*CRW-1 -: pim_pkg::VIDX_W]];
      vq_c <= vtx_mem_c[face_q[CRW-1 -: pim_pkg::VIDX_W]];
    end
  end

  assign x0 = vq_a[VW-1:CW];
  assign z0 = vq_a[CW-1:0];
  assign x1 = vq_b[VW-1:CW];
  assign z1 = vq_b[CW-1:0];
  assign x2 = vq_c[VW-1:CW];
  assign z2 = vq_c[CW-1:0];

  // edge and point offsets from the first corner, products, sums, sign fix
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px <= coord_x;
      pz <= coord_z;
    end
    ex1 <= DW'(x1) - DW'(x0);
    ez1 <= DW'(z1) - DW'(z0);
    ex2 <= DW'(x2) - DW'(x0);
    ez2 <= DW'(z2) - DW'(z0);
    qx  <= DW'(px) - DW'(x0);
    qz  <= DW'(pz) - DW'(z0);

    pr_d1 <= PW'(ex1) * PW'(ez2);
    pr_d2 <= PW'(ex2) * PW'(ez1);
    pr_s1 <= PW'(ez2) * PW'(qx);
    pr_s2 <= PW'(ex2) * PW'(qz);
    pr_t1 <= PW'(ex1) * PW'(qz);
    pr_t2 <= PW'(ez1) * PW'(qx);

    area  <= SW'(pr_d1) - SW'(pr_d2);
    s_num <= SW'(pr_s1) - SW'(pr_s2);
    t_num <= SW'(pr_t1) - SW'(pr_t2);

    if (area[SW-1]) begin
      area_n <= -area;
      s_n    <= -s_num;
      t_n    <= -t_num;
    end else begin
      area_n <= area;
      s_n    <= s_num;
      t_n    <= t_num;
    end
  end

  // strict test, a zero area fails on its own
  assign st_sum   = AW'(s_n) + AW'(t_n);
  assign face_hit = (s_n > 0) && (t_n > 0) && (st_sum < AW'(area_n));

  assign sts.walk_done  = (face_idx == face_limit);
  assign sts.hit_seen   = hit_any;
  assign sts.pipe_empty = ~|vld;
  assign inside_res     = hit_any;

endmodule

FILE: design/point_in_mesh_xz_test.sv
// top level of the point in mesh test in the xz plane
//
// usage
// - one input word per start pulse, taken at a rising edge with start high and busy low
// - op selects a vertex write (slot, coord_x, coord_z), a face write (slot and the
//   three corner indices) or a query point (coord_x, coord_z)
// - writes leave busy low and give no result
// - a query raises busy and walks faces 0 to faces_in_use-1, one face a cycle
//   through the face table read port, stopping early once a hit leaves the pipeline
// - done rises once the walk has stopped and the pipeline has drained; the walk stops
//   early only when a hit leaves the pipeline before the last face is issued; the
//   next word is taken the cycle after done
// - the result is on inside_res in the single cycle that done is high and until the
//   next query; the receiver cannot hold it off, so it must take it in that cycle
// - faces_in_use is to be written through cfg_we and cfg_data while the block is idle,
//   which it does not enforce; values above the face table depth test the whole table
// - coordinates are signed q8.8, the arithmetic is exact, and a triangle of
//   zero area never holds the point
// - reset clears the walk state and faces_in_use; the vertex and face tables are
//   not cleared, so only entries written since are meaningful
module point_in_mesh_xz_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pim_pkg::OP_W-1:0]       op,
  input  logic [pim_pkg::SLOT_W-1:0]     slot,
  input  logic signed [COORD_BITS-1:0]   coord_x,
  input  logic signed [COORD_BITS-1:0]   coord_z,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_a,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_b,
  input  logic [pim_pkg::CORNER_W-1:0]   corner_c,
  input  logic                           cfg_we,
  input  logic [pim_pkg::CFG_W-1:0]      cfg_data,
  output logic                           busy,
  output logic                           done,
  output logic                           inside_res
);

  // command and status between sequencer and datapath
  pim_pkg::cmd_t cmd;
  pim_pkg::sts_t sts;

  // sequencer: decodes the word, runs the walk, waits for the pipe to drain
  pim_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: tables, face counter and the six stage barycentric pipeline
  pim_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .slot       (slot),
    .coord_x    (coord_x),
    .coord_z    (coord_z),
    .corner_a   (corner_a),
    .corner_b   (corner_b),
    .corner_c   (corner_c),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .inside_res (inside_res)
  );

endmodule

FILE: design/pim_checker.sv
// port level checks of the point in mesh test and their binding
`include "assert_macros.svh"

module pim_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic [pim_pkg::OP_W-1:0] op,
  input logic                     busy,
  input logic                     done
);

  // a result only shows while a query is in flight
  `ASSERT_DIS(a_done_busy, clk, rst, done |-> busy)

  // the block is free again right after a result
  `ASSERT_DIS(a_done_free, clk, rst, done |=> !busy)

  // a query word keeps the block busy
  `ASSERT_DIS(a_query_busy, clk, rst,
    (start && !busy && op == pim_pkg::OP_QUERY) |=> busy)

  // a write or unused word leaves it idle with no result
  `ASSERT_DIS(a_write_idle, clk, rst,
    (start && !busy && op != pim_pkg::OP_QUERY) |=> (!busy && !done))

endmodule

bind point_in_mesh_xz_test pim_checker u_pim_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .op    (op),
  .busy  (busy),
  .done  (done)
);
